[rtl/core/xpcq_pkg.sv]
// xpcq_pkg: shared types, constants and palette function for the xterm palette quantizer.
// Used by xpcq_cell and xterm_palette_color_quantizer_top. No dependencies.
`default_nettype none

package xpcq_pkg;

	localparam int CHAN_W  = 8;
	localparam int MODE_W  = 2;
	localparam int INDEX_W = 8;
	localparam int DIST_W  = 18;	// 3 * 255^2 = 195075 fits

	localparam int NUM_CELLS  = 240;	// one cell per candidate of the 256 search
	localparam int CUBE_BASE  = 16;
	localparam int GRAY_BASE  = 232;
	localparam int ANSI_COUNT = 16;

	// color_mode register codes
	localparam logic [MODE_W-1:0] MODE_TRUECOLOR  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_INDEXED256 = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ANSI16     = 2'd2;

	// encoding output codes
	localparam logic [MODE_W-1:0] ENC_TRUECOLOR  = 2'd0;
	localparam logic [MODE_W-1:0] ENC_INDEXED256 = 2'd1;
	localparam logic [MODE_W-1:0] ENC_ANSI16     = 2'd2;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb_t;

	// payload handed from cell to cell
	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		rgb_t               src;
		logic [DIST_W-1:0]  best_dist;
		logic [INDEX_W-1:0] best_idx;
		rgb_t               best_rgb;
	} xpcq_word_t;

	localparam rgb_t BASE16 [ANSI_COUNT] = '{
		'{8'd0,   8'd0,   8'd0  }, '{8'd128, 8'd0,   8'd0  },
		'{8'd0,   8'd128, 8'd0  }, '{8'd128, 8'd128, 8'd0  },
		'{8'd0,   8'd0,   8'd128}, '{8'd128, 8'd0,   8'd128},
		'{8'd0,   8'd128, 8'd128}, '{8'd192, 8'd192, 8'd192},
		'{8'd128, 8'd128, 8'd128}, '{8'd255, 8'd0,   8'd0  },
		'{8'd0,   8'd255, 8'd0  }, '{8'd255, 8'd255, 8'd0  },
		'{8'd0,   8'd0,   8'd255}, '{8'd255, 8'd0,   8'd255},
		'{8'd0,   8'd255, 8'd255}, '{8'd255, 8'd255, 8'd255}
	};

	function automatic logic [CHAN_W-1:0] level_value(input int lvl);
		return (lvl == 0) ? '0 : CHAN_W'(55 + 40 * lvl);
	endfunction

	// Palette color of an index; only evaluated on constants at elaboration.
	function automatic rgb_t palette_rgb(input int idx);
		rgb_t c;
		int   off;
		int   v;
		off = 0;
		v   = 0;
		if (idx < CUBE_BASE) begin
			c = BASE16[idx];
		end else if (idx < GRAY_BASE) begin
			off     = idx - CUBE_BASE;
			c.red   = level_value(off / 36);
			c.green = level_value((off / 6) % 6);
			c.blue  = level_value(off % 6);
		end else begin
			v       = 8 + 10 * (idx - GRAY_BASE);
			c.red   = CHAN_W'(v);
			c.green = CHAN_W'(v);
			c.blue  = CHAN_W'(v);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

[rtl/core/xpcq_cell.sv]
// xpcq_cell: one candidate of the nearest-color search, one register stage.
// Depends on xpcq_pkg.
`default_nettype none

module xpcq_cell #(
	parameter int CELL_IDX = 0
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic                    prev_valid,
	input  wire xpcq_pkg::xpcq_word_t    prev_word,
	output logic                         next_valid,
	output xpcq_pkg::xpcq_word_t         next_word
);
	import xpcq_pkg::*;

	localparam bit   HAS_ANSI   = (CELL_IDX < ANSI_COUNT);
	localparam rgb_t COLOR_256  = palette_rgb(CUBE_BASE + CELL_IDX);
	localparam rgb_t COLOR_ANSI = palette_rgb(HAS_ANSI ? CELL_IDX : 0);
	localparam logic [INDEX_W-1:0] IDX_256  = INDEX_W'(CUBE_BASE + CELL_IDX);
	localparam logic [INDEX_W-1:0] IDX_ANSI = INDEX_W'(HAS_ANSI ? CELL_IDX : 0);

	rgb_t               cand;
	logic [INDEX_W-1:0] cand_idx;
	logic               active;
	logic [CHAN_W-1:0]  dr, dg, db;
	logic [DIST_W-1:0]  cand_dist;
	xpcq_word_t         word_d;
	logic               valid_q;
	xpcq_word_t         word_q;

	function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
	                                               input logic [CHAN_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	always_comb begin
		if (prev_word.mode == MODE_ANSI16) begin
			cand     = COLOR_ANSI;
			cand_idx = IDX_ANSI;
			active   = HAS_ANSI;
		end else begin
			cand     = COLOR_256;
			cand_idx = IDX_256;
			active   = (prev_word.mode == MODE_INDEXED256);
		end
		dr   = abs_diff(prev_word.src.red,   cand.red);
		dg   = abs_diff(prev_word.src.green, cand.green);
		db   = abs_diff(prev_word.src.blue,  cand.blue);
		cand_dist = (DIST_W'(dr) * DIST_W'(dr)) + (DIST_W'(dg) * DIST_W'(dg)) +
		            (DIST_W'(db) * DIST_W'(db));

		word_d = prev_word;
		// strict compare: earlier (lower) index keeps a tie
		if (active && (cand_dist < prev_word.best_dist)) begin
			word_d.best_dist = cand_dist;
			word_d.best_idx  = cand_idx;
			word_d.best_rgb  = cand;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_q <= word_d;
		end
	end

	assign next_valid = valid_q;
	assign next_word  = word_q;

endmodule

`default_nettype wire

[rtl/core/xterm_palette_color_quantizer_top.sv]
// xterm_palette_color_quantizer_top: nearest xterm palette match over a chain of cells.
// Depends on xpcq_pkg and xpcq_cell.
`default_nettype none

// Channel  | Handshake            | Payload
// ---------+----------------------+-----------------------------------------------
// input    | in_valid / in_stall  | in_red, in_green, in_blue
// output   | out_valid / out_stall| encoding, palette_index, out_red/green/blue
// config   | cfg_wr_en            | cfg_wr_data (color_mode)
//
// One word accepted per cycle while in_stall is low; each word passes through
// the 240-cell candidate chain (one palette entry per cell) and then the output register.
// Reset clears color_mode to truecolor and all stage valid bits.
// The whole chain advances together: a stalled output word freezes every
// stage and raises in_stall in the same cycle.

module xterm_palette_color_quantizer_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [xpcq_pkg::MODE_W-1:0]    cfg_wr_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [xpcq_pkg::CHAN_W-1:0]    in_red,
	input  wire logic [xpcq_pkg::CHAN_W-1:0]    in_green,
	input  wire logic [xpcq_pkg::CHAN_W-1:0]    in_blue,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [xpcq_pkg::MODE_W-1:0]         encoding,
	output logic [xpcq_pkg::INDEX_W-1:0]        palette_index,
	output logic [xpcq_pkg::CHAN_W-1:0]         out_red,
	output logic [xpcq_pkg::CHAN_W-1:0]         out_green,
	output logic [xpcq_pkg::CHAN_W-1:0]         out_blue
);
	import xpcq_pkg::*;

	logic [MODE_W-1:0] color_mode_q;
	logic              advance;
	logic              chain_valid [NUM_CELLS+1];
	xpcq_word_t        chain_word  [NUM_CELLS+1];
	xpcq_word_t        last_word;

	logic               out_valid_q;
	logic [MODE_W-1:0]  encoding_q;
	logic [INDEX_W-1:0] palette_index_q;
	rgb_t               out_rgb_q;

	// config register; the user must write it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q <= MODE_TRUECOLOR;
		end else if (cfg_wr_en) begin
			color_mode_q <= cfg_wr_data;
		end
	end

	// global advance: hold everything while the output word waits
	assign advance  = !(out_valid_q && out_stall);
	assign in_stall = !advance;

	// head of the chain: source color, no candidate yet
	assign chain_valid[0]          = in_valid;
	assign chain_word[0].mode      = color_mode_q;
	assign chain_word[0].src.red   = in_red;
	assign chain_word[0].src.green = in_green;
	assign chain_word[0].src.blue  = in_blue;
	assign chain_word[0].best_dist = DIST_MAX;
	assign chain_word[0].best_idx  = '0;
	assign chain_word[0].best_rgb  = '0;

	for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
		xpcq_cell #(
			.CELL_IDX(g)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (advance),
			.prev_valid (chain_valid[g]),
			.prev_word  (chain_word[g]),
			.next_valid (chain_valid[g+1]),
			.next_word  (chain_word[g+1])
		);
	end

	assign last_word = chain_word[NUM_CELLS];

	// output register: pick encoding and color by the mode the word carried
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= chain_valid[NUM_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			unique case (last_word.mode)
				MODE_INDEXED256: begin
					encoding_q      <= ENC_INDEXED256;
					palette_index_q <= last_word.best_idx;
					out_rgb_q       <= last_word.best_rgb;
				end
				MODE_ANSI16: begin
					encoding_q      <= ENC_ANSI16;
					palette_index_q <= last_word.best_idx;
					out_rgb_q       <= last_word.best_rgb;
				end
				default: begin
					// truecolor and the unused code pass the source through
					encoding_q      <= ENC_TRUECOLOR;
					palette_index_q <= '0;
					out_rgb_q       <= last_word.src;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign encoding      = encoding_q;
	assign palette_index = palette_index_q;
	assign out_red       = out_rgb_q.red;
	assign out_green     = out_rgb_q.green;
	assign out_blue      = out_rgb_q.blue;

endmodule

`default_nettype wire
